@@ sv/bafl_pkg.sv @@
// ----------------------------------------------------------------------------
// bafl_pkg
// Shared types and operation codes for the byte ALU with kept flags.
// ----------------------------------------------------------------------------
package bafl_pkg;

    localparam int DataWidth = 8;
    localparam int CmdWidth  = 4;

    typedef logic [DataWidth-1:0] data_t;
    typedef logic [CmdWidth-1:0]  cmd_bits_t;

    typedef enum logic [CmdWidth-1:0] {
        CMD_ADD = 4'd0,
        CMD_SUB = 4'd1,
        CMD_MUL = 4'd2,
        CMD_AND = 4'd3,
        CMD_OR  = 4'd4,
        CMD_XOR = 4'd5,
        CMD_NOT = 4'd6,
        CMD_LSH = 4'd7,
        CMD_RSH = 4'd8,
        CMD_INC = 4'd9,
        CMD_DEC = 4'd10
    } cmd_t;

    typedef struct packed {
        logic zero;
        logic underflow;
        logic overflow;
    } flags_t;

    localparam flags_t FlagsClear = '{zero: 1'b0, underflow: 1'b0, overflow: 1'b0};

endpackage

@@ sv/bafl_req_if.sv @@
// ----------------------------------------------------------------------------
// bafl_req_if
// Request channel: operation code and two byte operands.
// ----------------------------------------------------------------------------
interface bafl_req_if;
    logic                valid;
    logic                ready;
    bafl_pkg::cmd_bits_t command;
    bafl_pkg::data_t     operand_a;
    bafl_pkg::data_t     operand_b;

    modport source (output valid, output command, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input command, input operand_a, input operand_b,
                    output ready);
endinterface

@@ sv/bafl_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bafl_rsp_if
// Response channel: result byte and the kept flags.
// ----------------------------------------------------------------------------
interface bafl_rsp_if;
    logic            valid;
    logic            ready;
    bafl_pkg::data_t result;
    logic            overflow_flag;
    logic            underflow_flag;
    logic            zero_flag;

    modport source (output valid, output result, output overflow_flag,
                    output underflow_flag, output zero_flag, input ready);
    modport sink   (input valid, input result, input overflow_flag,
                    input underflow_flag, input zero_flag, output ready);
endinterface

@@ sv/bafl_alu.sv @@
// ----------------------------------------------------------------------------
// bafl_alu
// Combinational byte ALU: computes the result byte and the new kept flags.
// ----------------------------------------------------------------------------
module bafl_alu (
    input  bafl_pkg::cmd_bits_t command,
    input  bafl_pkg::data_t     operand_a,
    input  bafl_pkg::data_t     operand_b,
    input  bafl_pkg::flags_t    flags_in,
    output bafl_pkg::data_t     result,
    output bafl_pkg::flags_t    flags_out
);
    import bafl_pkg::*;

    logic [DataWidth:0]     sum;
    logic [DataWidth:0]     diff;
    logic [2*DataWidth-1:0] prod;
    data_t                  r;
    flags_t                 f;

    assign sum  = {1'b0, operand_a} + {1'b0, operand_b};
    assign diff = {1'b0, operand_a} - {1'b0, operand_b};
    assign prod = (2*DataWidth)'(operand_a) * (2*DataWidth)'(operand_b);

    always_comb
    begin
        r = '0;
        f = FlagsClear;
        unique case (cmd_t'(command))
            CMD_ADD:
            begin
                r          = sum[DataWidth-1:0];
                f.overflow = sum[DataWidth];
            end
            CMD_SUB:
            begin
                r           = diff[DataWidth-1:0];
                f.underflow = diff[DataWidth];
                f.zero      = (r == '0);
            end
            CMD_MUL:
            begin
                r          = prod[DataWidth-1:0];
                f.overflow = |prod[2*DataWidth-1:DataWidth];
                f.zero     = (r == '0);
            end
            CMD_AND:
            begin
                r      = operand_a & operand_b;
                f.zero = (r == '0);
            end
            CMD_OR:
            begin
                r      = operand_a | operand_b;
                f.zero = (r == '0);
            end
            CMD_XOR:
            begin
                r      = operand_a ^ operand_b;
                f.zero = (r == '0);
            end
            CMD_NOT:
            begin
                r      = ~operand_a;
                f.zero = (r == '0);
            end
            CMD_LSH:
            begin
                r          = {operand_a[DataWidth-2:0], 1'b0};
                f.overflow = operand_a[DataWidth-1];
                f.zero     = (r == '0);
            end
            CMD_RSH:
            begin
                r           = {1'b0, operand_a[DataWidth-1:1]};
                f.underflow = operand_a[0];
                f.zero      = (r == '0);
            end
            CMD_INC:
            begin
                r          = operand_a + data_t'(1);
                f          = flags_in;
                f.overflow = flags_in.overflow | (&operand_a);
            end
            CMD_DEC:
            begin
                r           = operand_a - data_t'(1);
                f           = flags_in;
                f.underflow = flags_in.underflow | (operand_a == '0);
            end
            default:
            begin
                // unused codes: no result, flags kept
                r = '0;
                f = flags_in;
            end
        endcase
    end

    assign result    = r;
    assign flags_out = f;

endmodule

@@ sv/byte_alu_with_flags_top.sv @@
// ----------------------------------------------------------------------------
// byte_alu_with_flags_top
// Byte ALU with kept overflow, underflow and zero flags.
//
// Channels: req carries command, operand_a and operand_b; rsp returns the
// result byte and the three kept flags, one response per request, in order.
// Both use valid/ready; a transfer happens on a clock edge with both high.
// Path: a request taken on req waits in the input register, passes the
// ALU and is held in the result register, from which rsp presents it.
// Throughput: one request per cycle while rsp accepts, set by the ALU path
// between the two registers; the kept flags update as each request moves
// into the result register, so back-to-back inc/dec chain correctly.
// Reset (rst_n low, asynchronous): both stages empty, all flags cleared.
// Receiver stall: the response holds in the result register; one more
// request can wait in the input register, after which req.ready drops.
// ----------------------------------------------------------------------------
module byte_alu_with_flags_top (
    input logic      clk,
    input logic      rst_n,
    bafl_req_if.sink   req,
    bafl_rsp_if.source rsp
);
    import bafl_pkg::*;

    logic      s1_valid_reg;
    logic      s1_valid_next;
    cmd_bits_t s1_cmd_reg;
    data_t     s1_a_reg;
    data_t     s1_b_reg;

    logic      out_valid_reg;
    logic      out_valid_next;
    data_t     result_reg;
    flags_t    flags_reg;

    data_t     alu_result;
    flags_t    alu_flags;
    logic      advance;
    logic      req_take;

    assign advance  = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign req_take = req.valid && req.ready;

    assign s1_valid_next  = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    bafl_alu u_alu (
        .command   (s1_cmd_reg),
        .operand_a (s1_a_reg),
        .operand_b (s1_b_reg),
        .flags_in  (flags_reg),
        .result    (alu_result),
        .flags_out (alu_flags)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= FlagsClear;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                flags_reg <= alu_flags;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            s1_cmd_reg <= req.command;
            s1_a_reg   <= req.operand_a;
            s1_b_reg   <= req.operand_b;
        end
        if (advance)
        begin
            result_reg <= alu_result;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.result         = result_reg;
    assign rsp.overflow_flag  = flags_reg.overflow;
    assign rsp.underflow_flag = flags_reg.underflow;
    assign rsp.zero_flag      = flags_reg.zero;

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("response register not loaded after advance");

    a_flags_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(flags_reg))
        else $error("kept flags changed without a request");

    a_inc_keeps_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_cmd_reg == CMD_INC && flags_reg.overflow) |=> flags_reg.overflow)
        else $error("inc cleared overflow");

    a_dec_keeps_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_cmd_reg == CMD_DEC && flags_reg.underflow) |=> flags_reg.underflow)
        else $error("dec cleared underflow");

    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> req.ready)
        else $error("input stage empty but not ready");

endmodule

@@ test/byte_alu_with_flags_top_tb.sv @@
// ----------------------------------------------------------------------------
// byte_alu_with_flags_top_tb
// Self-checking bench for the byte ALU with kept flags. Directed requests hit
// operand extremes, every command, flag carry-over through inc/dec and the
// unused command codes. Random requests then run under four traffic phases.
// A local ALU model predicts each response; responses are checked in order.
// ----------------------------------------------------------------------------
module byte_alu_with_flags_top_tb;

    import bafl_pkg::*;

    localparam int        StuckLimit  = 2000;
    localparam int        DrainCycles = 6;
    localparam cmd_bits_t CmdUnusedLo = 4'd11;
    localparam cmd_bits_t CmdUnusedHi = 4'd15;

    typedef struct packed {
        data_t  result;
        flags_t flags;
    } alu_out_t;

    logic clk;
    logic rst_n;

    bafl_req_if req_ch ();
    bafl_rsp_if rsp_ch ();

    byte_alu_with_flags_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    flags_t   kept_flags;
    alu_out_t alu_out_q[$];
    int       err_count;
    int       send_idle_pct;
    int       rsp_stall_pct;
    int       stuck_cycles;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic alu_out_t alu_compute(cmd_bits_t cmd, data_t a, data_t b);
        logic [15:0] wide;
        alu_out_t    o;
        flags_t      f;
        f        = FlagsClear;
        o.result = '0;
        case (cmd)
            CMD_ADD:
            begin
                wide          = 16'(a) + 16'(b);
                o.result      = wide[7:0];
                f.overflow    = wide[8];
            end
            CMD_SUB:
            begin
                o.result      = a - b;
                f.underflow   = (a < b);
                f.zero        = (o.result == '0);
            end
            CMD_MUL:
            begin
                wide          = 16'(a) * 16'(b);
                o.result      = wide[7:0];
                f.overflow    = (wide[15:8] != '0);
                f.zero        = (o.result == '0);
            end
            CMD_AND:
            begin
                o.result      = a & b;
                f.zero        = (o.result == '0);
            end
            CMD_OR:
            begin
                o.result      = a | b;
                f.zero        = (o.result == '0);
            end
            CMD_XOR:
            begin
                o.result      = a ^ b;
                f.zero        = (o.result == '0);
            end
            CMD_NOT:
            begin
                o.result      = ~a;
                f.zero        = (o.result == '0);
            end
            CMD_LSH:
            begin
                o.result      = {a[6:0], 1'b0};
                f.overflow    = a[7];
                f.zero        = (o.result == '0);
            end
            CMD_RSH:
            begin
                o.result      = {1'b0, a[7:1]};
                f.underflow   = a[0];
                f.zero        = (o.result == '0);
            end
            CMD_INC:
            begin
                f             = kept_flags;
                o.result      = a + 8'd1;
                if (a == 8'hFF)
                    f.overflow = 1'b1;
            end
            CMD_DEC:
            begin
                f             = kept_flags;
                o.result      = a - 8'd1;
                if (a == 8'h00)
                    f.underflow = 1'b1;
            end
            default:
            begin
                f             = kept_flags;
            end
        endcase
        kept_flags = f;
        o.flags    = f;
        return o;
    endfunction

    function automatic data_t pick_operand();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h01;
            default: return data_t'($urandom_range(0, 255));
        endcase
    endfunction

    // caller sits just after a rising edge
    task automatic send_req(input cmd_bits_t cmd, input data_t a, input data_t b);
        logic rdy;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.command   <= cmd;
        req_ch.operand_a <= a;
        req_ch.operand_b <= b;
        do
        begin
            @(negedge clk);
            rdy = req_ch.ready;
            @(posedge clk);
        end
        while (!rdy);
        alu_out_q.push_back(alu_compute(cmd, a, b));
    endtask

    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
    end

    // inputs only move at rising edges, so mid-cycle values are what the edge takes
    always @(negedge clk)
    begin
        alu_out_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (alu_out_q.size() == 0)
            begin
                $error("response with no request outstanding: result=%0h", rsp_ch.result);
                err_count++;
            end
            else
            begin
                want = alu_out_q.pop_front();
                if (rsp_ch.result !== want.result)
                begin
                    $error("result: expected %0h, got %0h", want.result, rsp_ch.result);
                    err_count++;
                end
                if (rsp_ch.overflow_flag !== want.flags.overflow)
                begin
                    $error("overflow_flag: expected %0b, got %0b",
                           want.flags.overflow, rsp_ch.overflow_flag);
                    err_count++;
                end
                if (rsp_ch.underflow_flag !== want.flags.underflow)
                begin
                    $error("underflow_flag: expected %0b, got %0b",
                           want.flags.underflow, rsp_ch.underflow_flag);
                    err_count++;
                end
                if (rsp_ch.zero_flag !== want.flags.zero)
                begin
                    $error("zero_flag: expected %0b, got %0b",
                           want.flags.zero, rsp_ch.zero_flag);
                    err_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= StuckLimit)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic test_arith_extremes();
        send_req(CMD_ADD, 8'hFF, 8'hFF);
        send_req(CMD_ADD, 8'h00, 8'h00);
        send_req(CMD_ADD, 8'hFF, 8'h01);
        send_req(CMD_SUB, 8'h00, 8'h01);
        send_req(CMD_SUB, 8'h5A, 8'h5A);
        send_req(CMD_SUB, 8'hFF, 8'h00);
        send_req(CMD_MUL, 8'h10, 8'h10);
        send_req(CMD_MUL, 8'h0F, 8'h11);
        send_req(CMD_MUL, 8'hFF, 8'hFF);
    endtask

    task automatic test_logic_shift();
        send_req(CMD_AND, 8'hFF, 8'h00);
        send_req(CMD_OR,  8'h00, 8'h00);
        send_req(CMD_XOR, 8'hAA, 8'h55);
        send_req(CMD_NOT, 8'hFF, 8'h00);
        send_req(CMD_NOT, 8'h00, 8'hFF);
        send_req(CMD_LSH, 8'h7F, 8'h00);
        send_req(CMD_RSH, 8'hFE, 8'h00);
    endtask

    // inc/dec must OR into flags left by the previous command
    task automatic test_inc_dec_chain();
        send_req(CMD_LSH, 8'h80, 8'h00);
        send_req(CMD_INC, 8'h10, 8'h00);
        send_req(CMD_RSH, 8'h01, 8'h00);
        send_req(CMD_DEC, 8'h00, 8'h00);
        send_req(CMD_INC, 8'hFF, 8'h00);
        send_req(CMD_ADD, 8'h01, 8'h01);
        send_req(CMD_DEC, 8'h01, 8'h00);
    endtask

    task automatic test_unused_codes();
        send_req(CMD_SUB, 8'h00, 8'h00);
        send_req(CmdUnusedLo, 8'hFF, 8'hFF);
        send_req(CmdUnusedHi, 8'h00, 8'h00);
    endtask

    task automatic test_random(input int n_req, input int idle_pct, input int stall_pct);
        cmd_bits_t cmd;
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        for (int i = 0; i < n_req; i++)
        begin
            // lean on inc/dec runs so kept flags build up over several requests
            if ($urandom_range(0, 3) == 0)
                cmd = ($urandom_range(0, 1) != 0) ? CMD_INC : CMD_DEC;
            else
                cmd = cmd_bits_t'($urandom_range(0, 15));
            send_req(cmd, pick_operand(), pick_operand());
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.command   = '0;
        req_ch.operand_a = '0;
        req_ch.operand_b = '0;
        rsp_ch.ready     = 1'b0;
        kept_flags       = FlagsClear;
        err_count        = 0;
        stuck_cycles     = 0;
        send_idle_pct    = 0;
        rsp_stall_pct    = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_arith_extremes();
        test_logic_shift();
        test_inc_dec_chain();
        test_unused_codes();
        test_random(175, 0, 0);
        test_random(175, 67, 0);
        test_random(175, 0, 67);
        test_random(175, 35, 35);

        req_ch.valid <= 1'b0;
        while (alu_out_q.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (alu_out_q.size() != 0)
        begin
            $error("%0d responses never arrived", alu_out_q.size());
            err_count++;
        end
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
